[design/fpq_pkg.sv]
package fpq_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int WORD_BITS     = 32;
  // The quotient is taken over the widened dividend, one bit per pipeline stage.
  localparam int DIV_BITS      = WORD_BITS + FRACTION_BITS;
  localparam int PROD_BITS     = 2 * WORD_BITS;
  localparam int KIND_BITS     = 4;
  localparam int IN_DATA_BITS  = 2 * WORD_BITS;
  localparam int OUT_USER_BITS = 2;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ADD      = 4'd0,
    KIND_SUB      = 4'd1,
    KIND_MUL      = 4'd2,
    KIND_DIV      = 4'd3,
    KIND_GT       = 4'd4,
    KIND_LT       = 4'd5,
    KIND_GE       = 4'd6,
    KIND_LE       = 4'd7,
    KIND_EQ       = 4'd8,
    KIND_NE       = 4'd9,
    KIND_INC      = 4'd10,
    KIND_DEC      = 4'd11,
    KIND_MIN      = 4'd12,
    KIND_MAX      = 4'd13,
    KIND_TO_INT   = 4'd14,
    KIND_FROM_INT = 4'd15
  } kind_t;

  // Everything one item carries down the divider chain.
  typedef struct packed {
    logic                is_div;
    logic                neg;
    logic                dz;
    logic                cmp;
    word_t               res;
    word_t               rem;
    logic [DIV_BITS-1:0] num;
    word_t               den;
    word_t               quo;
  } div_stage_t;

  // One restoring division step: bring down the next dividend bit and
  // subtract the divisor if it fits. The remainder stays below the divisor.
  function automatic div_stage_t div_step(input div_stage_t cur);
    div_stage_t           nxt;
    logic [WORD_BITS:0]   trial;
    logic [WORD_BITS:0]   diff;
    nxt   = cur;
    trial = {cur.rem, cur.num[DIV_BITS-1]};
    diff  = trial - {1'b0, cur.den};
    nxt.num = {cur.num[DIV_BITS-2:0], 1'b0};
    if (!diff[WORD_BITS]) begin
      nxt.rem = diff[WORD_BITS-1:0];
      nxt.quo = {cur.quo[WORD_BITS-2:0], 1'b1};
    end else begin
      nxt.rem = trial[WORD_BITS-1:0];
      nxt.quo = {cur.quo[WORD_BITS-2:0], 1'b0};
    end
    return nxt;
  endfunction

endpackage

[design/fixed_point_q24_8_alu.sv]
// Channel  Direction  Handshake          tdata                     tuser
// s_*      in         s_tvalid/s_tready  operand_a, operand_b      kind
// m_*      out        m_tvalid/m_tready  result                    compare_true, divide_by_zero
//
// One item enters per cycle while the output is not stalled. An accepted item passes
// through the input stage and the 40-stage divider chain into the output register; all
// items pass through the chain so results keep their order.
// Reset empties every stage; payload registers are not reset.
// A stall on the output freezes the whole pipeline; s_tready is high whenever
// the output register is empty or being taken.
module fixed_point_q24_8_alu (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [fpq_pkg::IN_DATA_BITS-1:0]       s_tdata,  // operand_a, operand_b
  input  logic [fpq_pkg::KIND_BITS-1:0]          s_tuser,  // kind
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [fpq_pkg::WORD_BITS-1:0]          m_tdata,  // result
  output logic [fpq_pkg::OUT_USER_BITS-1:0]      m_tuser   // compare_true, divide_by_zero
);

  logic                                   en;
  fpq_pkg::kind_t                         kind;
  logic signed [fpq_pkg::WORD_BITS-1:0]   a;
  logic signed [fpq_pkg::WORD_BITS-1:0]   b;
  logic                                   lt_ab;
  logic                                   gt_ab;
  logic                                   eq_ab;
  fpq_pkg::div_stage_t                    s1_next;
  logic signed [fpq_pkg::PROD_BITS-1:0]   prod_next;

  logic                                   s1_valid;
  fpq_pkg::div_stage_t                    s1;
  logic                                   s1_is_mul;
  logic signed [fpq_pkg::PROD_BITS-1:0]   s1_prod;

  fpq_pkg::div_stage_t                    head;
  fpq_pkg::div_stage_t                    pipe       [1:fpq_pkg::DIV_BITS];
  logic                                   pipe_valid [1:fpq_pkg::DIV_BITS];

  fpq_pkg::div_stage_t                    last;
  fpq_pkg::word_t                         res_next;
  fpq_pkg::word_t                         out_res;
  logic                                   out_cmp;
  logic                                   out_dz;
  logic                                   out_valid;

  assign en       = !out_valid || m_tready;
  assign s_tready = en;

  assign kind = fpq_pkg::kind_t'(s_tuser);
  assign a    = s_tdata[fpq_pkg::WORD_BITS-1:0];
  assign b    = s_tdata[2*fpq_pkg::WORD_BITS-1:fpq_pkg::WORD_BITS];

  assign lt_ab = a < b;
  assign gt_ab = b < a;
  assign eq_ab = a == b;

  assign prod_next = a * b;

  always_comb begin
    s1_next        = '0;
    s1_next.is_div = kind == fpq_pkg::KIND_DIV;
    s1_next.neg    = a[fpq_pkg::WORD_BITS-1] ^ b[fpq_pkg::WORD_BITS-1];
    s1_next.dz     = (kind == fpq_pkg::KIND_DIV) && (b == '0);
    s1_next.num    = {(a[fpq_pkg::WORD_BITS-1] ? fpq_pkg::word_t'(-a) : fpq_pkg::word_t'(a)),
                      {fpq_pkg::FRACTION_BITS{1'b0}}};
    s1_next.den    = b[fpq_pkg::WORD_BITS-1] ? fpq_pkg::word_t'(-b) : fpq_pkg::word_t'(b);
    unique case (kind)
      fpq_pkg::KIND_ADD:      s1_next.res = fpq_pkg::word_t'(a + b);
      fpq_pkg::KIND_SUB:      s1_next.res = fpq_pkg::word_t'(a - b);
      fpq_pkg::KIND_MUL:      s1_next.res = '0;
      fpq_pkg::KIND_DIV:      s1_next.res = '0;
      fpq_pkg::KIND_GT:       s1_next.cmp = gt_ab;
      fpq_pkg::KIND_LT:       s1_next.cmp = lt_ab;
      fpq_pkg::KIND_GE:       s1_next.cmp = !lt_ab;
      fpq_pkg::KIND_LE:       s1_next.cmp = !gt_ab;
      fpq_pkg::KIND_EQ:       s1_next.cmp = eq_ab;
      fpq_pkg::KIND_NE:       s1_next.cmp = !eq_ab;
      fpq_pkg::KIND_INC:      s1_next.res = fpq_pkg::word_t'(a + 1);
      fpq_pkg::KIND_DEC:      s1_next.res = fpq_pkg::word_t'(a - 1);
      fpq_pkg::KIND_MIN:      s1_next.res = lt_ab ? fpq_pkg::word_t'(a) : fpq_pkg::word_t'(b);
      fpq_pkg::KIND_MAX:      s1_next.res = gt_ab ? fpq_pkg::word_t'(a) : fpq_pkg::word_t'(b);
      fpq_pkg::KIND_TO_INT:   s1_next.res = fpq_pkg::word_t'(a >>> fpq_pkg::FRACTION_BITS);
      fpq_pkg::KIND_FROM_INT: s1_next.res = fpq_pkg::word_t'(a << fpq_pkg::FRACTION_BITS);
      default:                s1_next.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1        <= s1_next;
      s1_is_mul <= kind == fpq_pkg::KIND_MUL;
      s1_prod   <= prod_next;
    end
  end

  // The product is registered once before its fraction bits are dropped.
  always_comb begin
    head = s1;
    if (s1_is_mul) begin
      head.res = s1_prod[fpq_pkg::FRACTION_BITS +: fpq_pkg::WORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe_valid[1] <= 1'b0;
    end else if (en) begin
      pipe_valid[1] <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[1] <= fpq_pkg::div_step(head);
    end
  end

  for (genvar k = 1; k < fpq_pkg::DIV_BITS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        pipe_valid[k+1] <= 1'b0;
      end else if (en) begin
        pipe_valid[k+1] <= pipe_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pipe[k+1] <= fpq_pkg::div_step(pipe[k]);
      end
    end
  end

  assign last = pipe[fpq_pkg::DIV_BITS];

  always_comb begin
    priority if (!last.is_div) begin
      res_next = last.res;
    end else if (last.dz) begin
      res_next = '0;
    end else if (last.neg) begin
      res_next = -last.quo;
    end else begin
      res_next = last.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= pipe_valid[fpq_pkg::DIV_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_res <= res_next;
      out_cmp <= last.cmp;
      out_dz  <= last.dz;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res;
  assign m_tuser  = {out_dz, out_cmp};

endmodule

[design/fpq_chk.sv]
module fpq_chk (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   s_tready,
  input logic                                   m_tvalid,
  input logic                                   m_tready,
  input logic [fpq_pkg::WORD_BITS-1:0]          m_tdata,
  input logic [fpq_pkg::OUT_USER_BITS-1:0]      m_tuser
);

  // A waiting result item holds still until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  // An empty output register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // A divide by zero and a comparison item both report a zero result.
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[0] || m_tuser[1]) |-> m_tdata == '0)
    else $error("flagged item with nonzero result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("compare and divide-by-zero flags both set");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind fixed_point_q24_8_alu fpq_chk u_fpq_chk (.*);
